### rtl/motor_fault_qualifier_macros.svh
// assertion helpers for the fault qualifier
`ifndef MOTOR_FAULT_QUALIFIER_MACROS_SVH
`define MOTOR_FAULT_QUALIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, sampled on clk, off during reset
`define MFQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define MFQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define MFQ_ASSERT_IMP(lbl, ante, cons, msg)
`define MFQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### rtl/mfq_pkg.sv
`default_nettype none
package mfq_pkg;

  localparam int NUM_BOARDS = 6;
  localparam int ADDR_W     = (NUM_BOARDS > 1) ? $clog2(NUM_BOARDS) : 1;

  localparam int BOARD_W    = 3;
  localparam int CUR_W      = 16;
  localparam int TEMP_W     = 12;
  localparam int CCNT_W     = 8;
  localparam int TCNT_W     = 8;
  localparam int COMM_W     = 17;
  localparam int OCL_W      = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [1:0] {
    KIND_NONE    = 2'd0,
    KIND_CURRENT = 2'd1,
    KIND_COMM    = 2'd2,
    KIND_TEMP    = 2'd3
  } kind_t;

  localparam logic [1:0] ACT_NONE = 2'd0;
  localparam logic [1:0] ACT_ZERO = 2'd1;
  localparam logic [1:0] ACT_HOLD = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_OC_LIMIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REV_CUTOFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CUR_CNT_LIM = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OT_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TMP_CNT_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COM_CNT_LIM = 3'd5;

  // per-board persistence counters, one memory word
  typedef struct packed {
    logic [CCNT_W-1:0] cur;
    logic [COMM_W-1:0] comm;
    logic [TCNT_W-1:0] temp;
  } cnt_t;

  typedef struct packed {
    logic [OCL_W-1:0]         oc_limit;
    logic signed [CUR_W-1:0]  rev_cutoff;
    logic [CCNT_W-1:0]        cur_cnt_lim;
    logic signed [TEMP_W-1:0] ot_limit;
    logic [TCNT_W-1:0]        tmp_cnt_lim;
    logic [COMM_W-1:0]        com_cnt_lim;
  } cfg_t;

  function automatic logic [1:0] action_of(kind_t latch);
    logic [1:0] act;
    unique case (latch)
      KIND_CURRENT, KIND_TEMP: act = ACT_ZERO;
      KIND_COMM:               act = ACT_HOLD;
      default:                 act = ACT_NONE;
    endcase
    return act;
  endfunction

endpackage
`default_nettype wire

### rtl/mfq_cnt_store.sv
`default_nettype none
module mfq_cnt_store (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      rd_en,
  input  wire logic [mfq_pkg::ADDR_W-1:0] rd_addr,
  output mfq_pkg::cnt_t                  rd_data,
  input  wire logic                      wr_en,
  input  wire logic [mfq_pkg::ADDR_W-1:0] wr_addr,
  input  wire mfq_pkg::cnt_t             wr_data
);

  mfq_pkg::cnt_t mem [mfq_pkg::NUM_BOARDS];

  logic [mfq_pkg::NUM_BOARDS-1:0] vld_r;
  mfq_pkg::cnt_t                  rd_q_r;
  logic                           rd_vld_r;
  logic                           fwd_hit_r;
  mfq_pkg::cnt_t                  fwd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  // entry valid bits stand in for clearing the counters at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_vld_r  <= 1'b0;
      fwd_hit_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r  <= vld_r[rd_addr];
        // a write at the same edge as the read is missed by the array
        fwd_hit_r <= wr_en && (wr_addr == rd_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_hit_r ? fwd_data_r : (rd_vld_r ? rd_q_r : '0);

endmodule
`default_nettype wire

### rtl/mfq_check.sv
`default_nettype none
module mfq_check (
  input  wire mfq_pkg::cnt_t                  cnt_old,
  input  wire mfq_pkg::cfg_t                  cfg,
  input  wire logic signed [mfq_pkg::CUR_W-1:0]  cur,
  input  wire logic signed [mfq_pkg::TEMP_W-1:0] temp,
  input  wire logic                           hb,
  output mfq_pkg::cnt_t                       cnt_new,
  output mfq_pkg::kind_t                      kind
);

  logic                      skip;
  logic [mfq_pkg::CUR_W:0]   mag;
  logic                      cur_bad;
  logic                      hot;
  logic                      cur_fire;
  logic                      comm_fire;
  logic                      temp_fire;

  always_comb begin
    skip = cur < cfg.rev_cutoff;
    // magnitude one bit wider so the most negative value stays exact
    mag  = cur[mfq_pkg::CUR_W-1] ? ((mfq_pkg::CUR_W+1)'(0) - {cur[mfq_pkg::CUR_W-1], cur})
                                 : {1'b0, cur};
    cur_bad = mag > {2'b00, cfg.oc_limit};
    hot     = temp > cfg.ot_limit;

    cnt_new = cnt_old;

    if (!skip) begin
      if (cur_bad) begin
        cnt_new.cur = (cnt_old.cur == '1) ? cnt_old.cur : cnt_old.cur + 1'b1;
      end else begin
        cnt_new.cur = '0;
      end
    end
    cur_fire = !skip && (cnt_new.cur > cfg.cur_cnt_lim);

    if (!cur_fire) begin
      if (hb) begin
        cnt_new.comm = '0;
      end else begin
        cnt_new.comm = (cnt_old.comm == '1) ? cnt_old.comm : cnt_old.comm + 1'b1;
      end
    end
    comm_fire = !cur_fire && (cnt_new.comm > cfg.com_cnt_lim);

    if (!cur_fire && !comm_fire) begin
      if (hot) begin
        cnt_new.temp = (cnt_old.temp == '1) ? cnt_old.temp : cnt_old.temp + 1'b1;
      end else begin
        cnt_new.temp = '0;
      end
    end
    temp_fire = !cur_fire && !comm_fire && (cnt_new.temp > cfg.tmp_cnt_lim);

    priority if (cur_fire) begin
      kind = mfq_pkg::KIND_CURRENT;
    end else if (comm_fire) begin
      kind = mfq_pkg::KIND_COMM;
    end else if (temp_fire) begin
      kind = mfq_pkg::KIND_TEMP;
    end else begin
      kind = mfq_pkg::KIND_NONE;
    end
  end

endmodule
`default_nettype wire

### rtl/motor_fault_qualifier.sv
// Motor fault qualifier: takes one fault check per transaction and returns one
// result per transaction, in order. A check reads the board's persistence
// counters from a small registered-read memory in the cycle it is accepted;
// the compute stage updates them and writes them back as it hands its result to
// the output register. Back-to-back checks of the same board are
// served by forwarding the word being written, so a new check is accepted every
// cycle as long as the result side keeps taking results; the output register
// lets one result wait while the next check is read. Counters read as zero
// after reset without any clearing pass. Configuration writes take effect at
// once and are meant for idle periods only.
`default_nettype none
`include "motor_fault_qualifier_macros.svh"
module motor_fault_qualifier (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [mfq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [mfq_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [mfq_pkg::BOARD_W-1:0]         in_board_id,
  input  wire logic signed [mfq_pkg::CUR_W-1:0]    in_motor_current,
  input  wire logic signed [mfq_pkg::TEMP_W-1:0]   in_motor_temp,
  input  wire logic                                in_heartbeat_seen,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_fault,
  output logic [1:0]                               out_fault_kind,
  output logic [1:0]                               out_latched_error,
  output logic [1:0]                               out_recovery_action
);

  mfq_pkg::cfg_t  cfg_r;

  logic                              s1_vld_r;
  logic                              s1_in_range_r;
  logic [mfq_pkg::ADDR_W-1:0]        s1_addr_r;
  logic signed [mfq_pkg::CUR_W-1:0]  s1_cur_r;
  logic signed [mfq_pkg::TEMP_W-1:0] s1_temp_r;
  logic                              s1_hb_r;

  mfq_pkg::kind_t latch_r;
  mfq_pkg::kind_t latch_nxt;
  logic           out_vld_r;

  logic                       in_acc;
  logic                       in_range;
  logic [mfq_pkg::ADDR_W-1:0] in_addr;
  logic                       adv;
  logic                       wr_en;
  mfq_pkg::cnt_t              cnt_old;
  mfq_pkg::cnt_t              cnt_new;
  mfq_pkg::kind_t             kind;
  mfq_pkg::kind_t             kind_eff;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.oc_limit    <= 15'd2500;
      cfg_r.rev_cutoff  <= -16'sd1000;
      cfg_r.cur_cnt_lim <= 8'd60;
      cfg_r.ot_limit    <= 12'sd800;
      cfg_r.tmp_cnt_lim <= 8'd60;
      cfg_r.com_cnt_lim <= 17'd100000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mfq_pkg::REG_OC_LIMIT:    cfg_r.oc_limit    <= cfg_wdata[mfq_pkg::OCL_W-1:0];
        mfq_pkg::REG_REV_CUTOFF:  cfg_r.rev_cutoff  <= cfg_wdata[mfq_pkg::CUR_W-1:0];
        mfq_pkg::REG_CUR_CNT_LIM: cfg_r.cur_cnt_lim <= cfg_wdata[mfq_pkg::CCNT_W-1:0];
        mfq_pkg::REG_OT_LIMIT:    cfg_r.ot_limit    <= cfg_wdata[mfq_pkg::TEMP_W-1:0];
        mfq_pkg::REG_TMP_CNT_LIM: cfg_r.tmp_cnt_lim <= cfg_wdata[mfq_pkg::TCNT_W-1:0];
        mfq_pkg::REG_COM_CNT_LIM: cfg_r.com_cnt_lim <= cfg_wdata[mfq_pkg::COMM_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_range = (in_board_id != '0) && (int'(in_board_id) <= mfq_pkg::NUM_BOARDS);
  assign in_addr  = mfq_pkg::ADDR_W'(in_board_id - mfq_pkg::BOARD_W'(1));

  assign adv      = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || adv;
  assign in_acc   = in_valid && in_ready;
  assign wr_en    = adv && s1_in_range_r;

  mfq_cnt_store u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc && in_range),
    .rd_addr (in_addr),
    .rd_data (cnt_old),
    .wr_en   (wr_en),
    .wr_addr (s1_addr_r),
    .wr_data (cnt_new)
  );

  mfq_check u_check (
    .cnt_old (cnt_old),
    .cfg     (cfg_r),
    .cur     (s1_cur_r),
    .temp    (s1_temp_r),
    .hb      (s1_hb_r),
    .cnt_new (cnt_new),
    .kind    (kind)
  );

  assign kind_eff  = s1_in_range_r ? kind : mfq_pkg::KIND_NONE;
  assign latch_nxt = (kind_eff != mfq_pkg::KIND_NONE) ? kind_eff : latch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      latch_r   <= mfq_pkg::KIND_NONE;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (adv) begin
        s1_vld_r <= 1'b0;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        latch_r   <= latch_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload of the compute stage and the output register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_in_range_r <= in_range;
      s1_addr_r     <= in_addr;
      s1_cur_r      <= in_motor_current;
      s1_temp_r     <= in_motor_temp;
      s1_hb_r       <= in_heartbeat_seen;
    end
    if (adv) begin
      out_fault           <= kind_eff != mfq_pkg::KIND_NONE;
      out_fault_kind      <= kind_eff;
      out_latched_error   <= latch_nxt;
      out_recovery_action <= mfq_pkg::action_of(latch_nxt);
    end
  end

  assign out_valid = out_vld_r;

  `MFQ_ASSERT_IMP(a_stall_needs_item, !in_ready, s1_vld_r, "input stalled with empty stage")
  `MFQ_ASSERT_IMP(a_fault_matches_kind, out_vld_r,
    out_fault == (out_fault_kind != mfq_pkg::KIND_NONE), "fault flag disagrees with kind")
  `MFQ_ASSERT_NEXT(a_latch_follows_fault, adv && (kind_eff != mfq_pkg::KIND_NONE),
    latch_r == $past(kind_eff), "error latch missed a fault")
  `MFQ_ASSERT_NEXT(a_no_write_out_of_range, adv && !s1_in_range_r,
    latch_r == $past(latch_r), "latch changed on an out-of-range board")

endmodule
`default_nettype wire
